/* rtl/mktbp_pkg.sv */
// Shared types and constants of the MAC-keyed token bucket policer.
package mktbp_pkg;

	localparam int MAC_W    = 48;
	localparam int TIME_W   = 32;
	localparam int LEN_W    = 16;
	localparam int RATE_W   = 32;
	localparam int TOKEN_W  = 40;
	localparam int SHIFT_W  = 5;
	localparam int SLOTID_W = 4;
	localparam int ADD_W    = RATE_W + TIME_W;
	localparam int SUM_W    = ADD_W + 1;
	localparam int BITS_W   = LEN_W + 3 + 31;

	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_LOAD   = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [TIME_W-1:0]   time_ms;
		logic [MAC_W-1:0]    src_mac;
		logic [MAC_W-1:0]    dst_mac;
		logic [LEN_W-1:0]    length_bytes;
		logic [SLOTID_W-1:0] entry_index;
		logic [MAC_W-1:0]    entry_mac;
		logic [RATE_W-1:0]   entry_rate;
		logic [TOKEN_W-1:0]  entry_cap;
		logic [SHIFT_W-1:0]  entry_shift;
		logic                entry_enable;
	} req_t;

	typedef struct packed {
		logic                forward;
		logic                matched;
		logic [SLOTID_W-1:0] drop_slot;
	} rsp_t;

	typedef struct packed {
		logic [MAC_W-1:0]   mac;
		logic [RATE_W-1:0]  rate;
		logic [TOKEN_W-1:0] cap;
		logic [SHIFT_W-1:0] shift;
		logic [TOKEN_W-1:0] bkt_from;
		logic [TOKEN_W-1:0] bkt_to;
		logic [TIME_W-1:0]  last;
	} slot_t;

	typedef struct packed {
		logic capture;
		logic load_wr;
		logic mul_en;
		logic refill_en;
		logic charge_en;
		logic next;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_load;
		logic walk_end;
		logic slot_valid;
		logic slot_hit;
		logic charge_ok;
		logic out_busy;
	} ctl_stat_t;

endpackage

/* rtl/mktbp_req_if.sv */
// Request channel: valid/ready handshake carrying one policer request.
interface mktbp_req_if;
	import mktbp_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/mktbp_rsp_if.sv */
// Response channel: valid/ready handshake carrying one policing verdict.
interface mktbp_rsp_if;
	import mktbp_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/mktbp_ctrl.sv */
// Controller state machine sequencing loads and the slot walk.
module mktbp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  mktbp_pkg::ctl_stat_t  stat,
	output mktbp_pkg::ctl_cmd_t   cmd
);
	import mktbp_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_READ     = 3'd2;
	localparam logic [2:0] ST_MATCH    = 3'd3;
	localparam logic [2:0] ST_REFILL   = 3'd4;
	localparam logic [2:0] ST_CHARGE   = 3'd5;
	localparam logic [2:0] ST_FINISH   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.is_load) begin
					cmd.load_wr = 1'b1;
					state_d     = ST_FINISH;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (stat.walk_end) begin
					state_d = ST_FINISH;
				end else if (!stat.slot_valid) begin
					cmd.next = 1'b1;
				end else begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				if (stat.slot_hit) begin
					cmd.mul_en = 1'b1;
					state_d    = ST_REFILL;
				end else begin
					cmd.next = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_REFILL: begin
				cmd.refill_en = 1'b1;
				state_d       = ST_CHARGE;
			end
			ST_CHARGE: begin
				cmd.charge_en = 1'b1;
				if (stat.charge_ok) begin
					cmd.next = 1'b1;
					state_d  = ST_READ;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

/* rtl/mktbp_dp.sv */
// Datapath: slot table memory, refill and charge arithmetic, response register.
module mktbp_dp #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mktbp_pkg::req_t       req_data,
	input  mktbp_pkg::ctl_cmd_t   cmd,
	output mktbp_pkg::ctl_stat_t  stat,
	input  logic                  rsp_ready,
	output logic                  rsp_valid,
	output mktbp_pkg::rsp_t       rsp_data
);
	import mktbp_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int EW = (IW > SLOTID_W) ? IW : SLOTID_W;

	req_t                 item_q;
	logic [CW-1:0]        idx_q;
	logic [NUM_SLOTS-1:0] valid_q;
	slot_t                slot_mem_q [NUM_SLOTS];
	slot_t                rd_q;
	logic [ADD_W-1:0]     add_q;
	logic                 from_q;
	logic [TOKEN_W-1:0]   bkt_from_q;
	logic [TOKEN_W-1:0]   bkt_to_q;
	logic [BITS_W-1:0]    bits_q;
	logic                 fwd_q;
	logic                 matched_q;
	logic [SLOTID_W-1:0]  drop_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_data_q;

	logic [EW-1:0]        idx_ext;
	logic                 load_in_range;
	logic [IW-1:0]        load_addr;
	logic [IW-1:0]        rd_addr;
	slot_t                load_entry;
	slot_t                wb_entry;
	logic                 hit_from;
	logic                 hit_any;
	logic [TIME_W-1:0]    periods;
	logic [ADD_W-1:0]     product;
	logic [SUM_W-1:0]     sum_from;
	logic [SUM_W-1:0]     sum_to;
	logic [TOKEN_W-1:0]   sel_bkt;
	logic                 charge_ok;
	logic [TOKEN_W-1:0]   charged;

	assign idx_ext       = EW'(item_q.entry_index);
	assign load_in_range = {1'b0, idx_ext} < (EW + 1)'(NUM_SLOTS);
	assign load_addr     = idx_ext[IW-1:0];
	assign rd_addr       = idx_q[IW-1:0];

	always_comb begin
		load_entry          = '0;
		load_entry.mac      = item_q.entry_mac;
		load_entry.rate     = item_q.entry_rate;
		load_entry.cap      = item_q.entry_cap;
		load_entry.shift    = item_q.entry_shift;
	end

	assign hit_from = (rd_q.mac == item_q.src_mac);
	assign hit_any  = hit_from || (rd_q.mac == item_q.dst_mac);
	assign periods  = item_q.time_ms - rd_q.last;
	assign product  = periods * rd_q.rate;

	assign sum_from = SUM_W'(rd_q.bkt_from) + SUM_W'(add_q);
	assign sum_to   = SUM_W'(rd_q.bkt_to) + SUM_W'(add_q);

	assign sel_bkt   = from_q ? bkt_from_q : bkt_to_q;
	assign charge_ok = BITS_W'(sel_bkt) >= bits_q;
	assign charged   = sel_bkt - bits_q[TOKEN_W-1:0];

	always_comb begin
		wb_entry          = rd_q;
		wb_entry.bkt_from = (from_q && charge_ok) ? charged : bkt_from_q;
		wb_entry.bkt_to   = (!from_q && charge_ok) ? charged : bkt_to_q;
		wb_entry.last     = item_q.time_ms;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && load_in_range) begin
			slot_mem_q[load_addr] <= load_entry;
		end else if (cmd.charge_en) begin
			slot_mem_q[rd_addr] <= wb_entry;
		end
		rd_q <= slot_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.load_wr && load_in_range) begin
			valid_q[load_addr] <= item_q.entry_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.capture) begin
			idx_q <= '0;
		end else if (cmd.next) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q    <= req_data;
			fwd_q     <= 1'b1;
			matched_q <= 1'b0;
			drop_q    <= '0;
		end
		if (cmd.mul_en) begin
			add_q  <= product;
			from_q <= hit_from;
		end
		if (cmd.refill_en) begin
			bkt_from_q <= (sum_from >= SUM_W'(rd_q.cap)) ? rd_q.cap : sum_from[TOKEN_W-1:0];
			bkt_to_q   <= (sum_to >= SUM_W'(rd_q.cap)) ? rd_q.cap : sum_to[TOKEN_W-1:0];
			bits_q     <= BITS_W'({item_q.length_bytes, 3'b000}) << rd_q.shift;
		end
		if (cmd.charge_en) begin
			matched_q <= 1'b1;
			if (!charge_ok) begin
				fwd_q  <= 1'b0;
				drop_q <= SLOTID_W'(idx_q);
			end
		end
		if (cmd.finish) begin
			rsp_data_q.forward   <= fwd_q;
			rsp_data_q.matched   <= matched_q;
			rsp_data_q.drop_slot <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign stat.is_load    = (item_q.kind == KIND_LOAD);
	assign stat.walk_end   = (idx_q == CW'(NUM_SLOTS));
	assign stat.slot_valid = valid_q[rd_addr];
	assign stat.slot_hit   = hit_any;
	assign stat.charge_ok  = charge_ok;
	assign stat.out_busy   = rsp_valid_q && !rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;
endmodule

/* rtl/mac_keyed_token_bucket_policer_core.sv */
// MAC-keyed token bucket policer top level: controller plus datapath.
// A load request writes one slot when its index is in range, then raises its
// verdict. A packet request walks the slot table in index order through the
// single-port slot memory: an invalid slot is skipped, a valid slot whose MAC
// does not match is read and compared, and a matching slot passes through the
// read, multiply, refill and charge steps. A verdict rises in the same cycle
// as the block becomes free again. The walk stops at the first slot that
// refuses the packet, which skips the final end-of-table check.
// The next request is taken while a finished verdict still waits on the
// response channel; that request then holds in its last cycle until the waiting
// verdict is taken. Reset clears all slot valid bits at once; no clearing pass.
module mac_keyed_token_bucket_policer_core #(
	parameter int NUM_SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	mktbp_req_if.sink          req,
	mktbp_rsp_if.source        rsp
);
	import mktbp_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	mktbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mktbp_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data)
	);
endmodule

/* rtl/mktbp_checker.sv */
// Port-level checks of the policer top level and their bind.
module mktbp_checker (
	input logic          clk,
	input logic          arst_n,
	mktbp_req_if.sink    req,
	mktbp_rsp_if.source  rsp
);
	import mktbp_pkg::*;

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req.valid && req.ready;
	assign rsp_acc = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (!req_acc && rsp_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("response changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req.ready)
		else $error("request taken while previous one in work");

	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> pend_q <= 2'd1)
		else $error("request taken with two requests outstanding");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> pend_q != 2'd0)
		else $error("response with no outstanding request");
endmodule

bind mac_keyed_token_bucket_policer_core mktbp_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

/* sim/tb_top.sv */
// Testbench for the MAC-keyed token bucket policer: directed and random requests checked against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mktbp_pkg::*;

	localparam int NUM_SLOTS    = 16;
	localparam int RANDOM_ITEMS = 1000;
	localparam int PHASES       = 8;
	localparam int IDLE_LIMIT   = 4000;
	localparam int WALK_CYCLES  = 80;

	localparam logic [MAC_W-1:0] MAC_A    = 48'h02_00_00_00_00_0A;
	localparam logic [MAC_W-1:0] MAC_C    = 48'h02_00_00_00_00_0C;
	localparam logic [MAC_W-1:0] MAC_D    = 48'h02_00_00_00_00_0D;
	localparam logic [MAC_W-1:0] MAC_E    = 48'h02_00_00_00_00_0E;
	localparam logic [MAC_W-1:0] MAC_X    = 48'h0A_0B_0C_0D_0E_0F;
	localparam logic [MAC_W-1:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;

	logic clk;
	logic arst_n;

	mktbp_req_if req_ch ();
	mktbp_rsp_if rsp_ch ();

	mac_keyed_token_bucket_policer_core #(
		.NUM_SLOTS(NUM_SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	bit                 tbl_valid    [NUM_SLOTS];
	logic [MAC_W-1:0]   tbl_mac      [NUM_SLOTS];
	logic [RATE_W-1:0]  tbl_rate     [NUM_SLOTS];
	logic [TOKEN_W-1:0] tbl_cap      [NUM_SLOTS];
	logic [SHIFT_W-1:0] tbl_shift    [NUM_SLOTS];
	logic [TOKEN_W-1:0] tbl_bkt_from [NUM_SLOTS];
	logic [TOKEN_W-1:0] tbl_bkt_to   [NUM_SLOTS];
	logic [TIME_W-1:0]  tbl_last     [NUM_SLOTS];

	rsp_t pending_verdicts[$];
	rsp_t want_verdict;
	rsp_t seen_verdict;
	int   mismatches;
	int   idle_cycles;
	int   n_packets;
	int   n_loads;
	int   n_matched;
	int   n_dropped;

	int   burst_left;
	bit   sender_gaps_on;
	int   rx_cycle;
	int   rx_mode;
	int   rx_stall_left;

	logic [MAC_W-1:0] traffic_macs[4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned topped_up(longint unsigned level,
			longint unsigned add, longint unsigned cap);
		if (level >= cap)
			return cap;
		if (add >= cap - level)
			return cap;
		return level + add;
	endfunction

	function automatic rsp_t police_request(req_t r);
		rsp_t            v;
		longint unsigned add;
		longint unsigned bits;
		longint unsigned cap;
		logic [TIME_W-1:0] periods;
		bit              from_host;
		bit              stop;
		v.forward   = 1'b1;
		v.matched   = 1'b0;
		v.drop_slot = '0;
		if (r.kind == KIND_LOAD) begin
			if (int'(r.entry_index) < NUM_SLOTS) begin
				tbl_mac[r.entry_index]      = r.entry_mac;
				tbl_rate[r.entry_index]     = r.entry_rate;
				tbl_cap[r.entry_index]      = r.entry_cap;
				tbl_shift[r.entry_index]    = r.entry_shift;
				tbl_valid[r.entry_index]    = r.entry_enable;
				tbl_bkt_from[r.entry_index] = '0;
				tbl_bkt_to[r.entry_index]   = '0;
				tbl_last[r.entry_index]     = '0;
			end
			return v;
		end
		stop = 1'b0;
		for (int i = 0; i < NUM_SLOTS && !stop; i++) begin
			if (tbl_valid[i] && (tbl_mac[i] == r.src_mac || tbl_mac[i] == r.dst_mac)) begin
				from_host = (tbl_mac[i] == r.src_mac);
				v.matched = 1'b1;
				periods = r.time_ms - tbl_last[i];
				tbl_last[i] = r.time_ms;
				add = 64'(periods) * 64'(tbl_rate[i]);
				cap = 64'(tbl_cap[i]);
				tbl_bkt_from[i] = TOKEN_W'(topped_up(64'(tbl_bkt_from[i]), add, cap));
				tbl_bkt_to[i]   = TOKEN_W'(topped_up(64'(tbl_bkt_to[i]), add, cap));
				bits = (64'(r.length_bytes) << 3) << tbl_shift[i];
				if (from_host && 64'(tbl_bkt_from[i]) >= bits) begin
					tbl_bkt_from[i] = tbl_bkt_from[i] - TOKEN_W'(bits);
				end else if (!from_host && 64'(tbl_bkt_to[i]) >= bits) begin
					tbl_bkt_to[i] = tbl_bkt_to[i] - TOKEN_W'(bits);
				end else begin
					v.forward   = 1'b0;
					v.drop_slot = SLOTID_W'(i);
					stop        = 1'b1;
				end
			end
		end
		return v;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				want_verdict = police_request(req_ch.data);
				pending_verdicts.push_back(want_verdict);
				if (req_ch.data.kind == KIND_LOAD) begin
					n_loads++;
				end else begin
					n_packets++;
					n_matched += want_verdict.matched;
					n_dropped += !want_verdict.forward;
				end
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen_verdict = rsp_ch.data;
				if (pending_verdicts.size() == 0) begin
					$error("verdict with no request outstanding: forward %0d matched %0d slot %0d",
						seen_verdict.forward, seen_verdict.matched, seen_verdict.drop_slot);
					mismatches++;
				end else begin
					want_verdict = pending_verdicts.pop_front();
					if (seen_verdict.forward !== want_verdict.forward) begin
						$error("forward: expected %0d, actual %0d",
							want_verdict.forward, seen_verdict.forward);
						mismatches++;
					end
					if (seen_verdict.matched !== want_verdict.matched) begin
						$error("matched: expected %0d, actual %0d",
							want_verdict.matched, seen_verdict.matched);
						mismatches++;
					end
					if (seen_verdict.drop_slot !== want_verdict.drop_slot) begin
						$error("drop_slot: expected %0d, actual %0d",
							want_verdict.drop_slot, seen_verdict.drop_slot);
						mismatches++;
					end
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		rsp_ch.ready  = 1'b0;
		rx_cycle      = 0;
		rx_mode       = 0;
		rx_stall_left = 0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle % 300 == 0)
				rx_mode = $urandom_range(0, 2);
			case (rx_mode)
				0: begin
					rsp_ch.ready <= 1'b1;
				end
				1: begin
					rsp_ch.ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					if (rx_stall_left > 0)
						rx_stall_left--;
					else if ($urandom_range(0, 7) == 0)
						rx_stall_left = $urandom_range(1, 30);
					rsp_ch.ready <= (rx_stall_left == 0);
				end
			endcase
		end
	end

	function automatic req_t random_request();
		req_t r;
		r.kind         = 1'($urandom_range(0, 1));
		r.time_ms      = $urandom();
		r.src_mac      = 48'({$urandom(), $urandom()});
		r.dst_mac      = 48'({$urandom(), $urandom()});
		r.length_bytes = 16'($urandom());
		r.entry_index  = 4'($urandom());
		r.entry_mac    = 48'({$urandom(), $urandom()});
		r.entry_rate   = $urandom();
		r.entry_cap    = 40'({$urandom(), $urandom()});
		r.entry_shift  = 5'($urandom());
		r.entry_enable = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic req_t make_load(logic [SLOTID_W-1:0] idx, logic [MAC_W-1:0] mac,
			logic [RATE_W-1:0] rate, logic [TOKEN_W-1:0] cap, logic [SHIFT_W-1:0] shift,
			logic en);
		req_t r;
		r              = random_request();
		r.kind         = KIND_LOAD;
		r.entry_index  = idx;
		r.entry_mac    = mac;
		r.entry_rate   = rate;
		r.entry_cap    = cap;
		r.entry_shift  = shift;
		r.entry_enable = en;
		return r;
	endfunction

	function automatic req_t make_packet(logic [TIME_W-1:0] t, logic [MAC_W-1:0] src,
			logic [MAC_W-1:0] dst, logic [LEN_W-1:0] len);
		req_t r;
		r              = random_request();
		r.kind         = KIND_PACKET;
		r.time_ms      = t;
		r.src_mac      = src;
		r.dst_mac      = dst;
		r.length_bytes = len;
		return r;
	endfunction

	task automatic send_request(input req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = sender_gaps_on ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain_verdicts();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_table();
		send_request(make_packet(32'd100, MAC_A, MAC_C, 16'd64));
	endtask

	task automatic test_zero_length_and_empty_bucket();
		send_request(make_load(4'd0, MAC_A, 32'd0, 40'd0, 5'd0, 1'b1));
		send_request(make_packet(32'd5, MAC_A, MAC_X, 16'd0));
		send_request(make_packet(32'd6, MAC_A, MAC_X, 16'd1));
	endtask

	task automatic test_extremes();
		send_request(make_load(4'd15, MAC_ONES, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 5'd31, 1'b1));
		send_request(make_packet(32'hFFFF_FFFF, 48'h0, MAC_ONES, 16'hFFFF));
		send_request(make_packet(32'hFFFF_FFFF, 48'h0, MAC_ONES, 16'h0));
	endtask

	task automatic test_direction();
		send_request(make_load(4'd3, MAC_C, 32'd100, 40'd800, 5'd0, 1'b1));
		send_request(make_packet(32'd10, MAC_C, MAC_C, 16'd100));
		send_request(make_packet(32'd10, MAC_X, MAC_C, 16'd100));
		send_request(make_packet(32'd10, MAC_C, MAC_X, 16'd1));
	endtask

	task automatic test_disable();
		send_request(make_load(4'd3, MAC_C, 32'd100, 40'd800, 5'd0, 1'b0));
		send_request(make_packet(32'd20, MAC_C, MAC_X, 16'd1));
	endtask

	task automatic test_walk_stop();
		send_request(make_load(4'd5, MAC_D, 32'd1000, 40'd1000000, 5'd0, 1'b1));
		send_request(make_load(4'd6, MAC_D, 32'd0, 40'd0, 5'd0, 1'b1));
		send_request(make_load(4'd7, MAC_D, 32'd1000, 40'd1000000, 5'd0, 1'b1));
		send_request(make_packet(32'd5, MAC_D, MAC_X, 16'd10));
		send_request(make_packet(32'd6, MAC_X, MAC_D, 16'd0));
	endtask

	task automatic test_time_wrap();
		send_request(make_load(4'd9, MAC_E, 32'd1, 40'd1000, 5'd0, 1'b1));
		send_request(make_packet(32'hFFFF_FFF0, MAC_E, MAC_X, 16'd0));
		send_request(make_packet(32'hFFFF_FFF0, MAC_E, MAC_X, 16'd125));
		send_request(make_packet(32'h0000_0010, MAC_E, MAC_X, 16'd4));
		send_request(make_packet(32'h0000_0010, MAC_E, MAC_X, 16'd1));
	endtask

	function automatic req_t random_load();
		logic [RATE_W-1:0]  rate;
		logic [TOKEN_W-1:0] cap;
		logic [SHIFT_W-1:0] shift;
		case ($urandom_range(0, 3))
			0:       rate = '0;
			1:       rate = $urandom_range(1, 2000);
			2:       rate = $urandom_range(2000, 200000);
			default: rate = $urandom();
		endcase
		case ($urandom_range(0, 3))
			0:       cap = 40'($urandom_range(0, 20000));
			1:       cap = 40'($urandom_range(20000, 2000000));
			2:       cap = 40'({$urandom(), $urandom()});
			default: cap = '1;
		endcase
		shift = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
		return make_load(4'($urandom()), traffic_macs[$urandom_range(0, 3)], rate, cap, shift,
			$urandom_range(0, 9) != 0);
	endfunction

	function automatic req_t random_packet(logic [TIME_W-1:0] t);
		logic [MAC_W-1:0] src;
		logic [MAC_W-1:0] dst;
		logic [LEN_W-1:0] len;
		src = 48'({$urandom(), $urandom()});
		dst = 48'({$urandom(), $urandom()});
		case ($urandom_range(0, 19))
			0, 1, 2: begin
			end
			3, 4, 5, 6, 7, 8, 9: begin
				src = traffic_macs[$urandom_range(0, 3)];
			end
			10, 11, 12, 13, 14, 15: begin
				dst = traffic_macs[$urandom_range(0, 3)];
			end
			default: begin
				src = traffic_macs[$urandom_range(0, 3)];
				dst = traffic_macs[$urandom_range(0, 3)];
			end
		endcase
		case ($urandom_range(0, 9))
			0:       len = 16'($urandom_range(0, 39));
			1:       len = 16'($urandom());
			default: len = 16'($urandom_range(40, 1500));
		endcase
		return make_packet(t, src, dst, len);
	endfunction

	task automatic test_random_traffic(input int n_items);
		logic [TIME_W-1:0] now;
		int                per_phase;
		per_phase = n_items / PHASES;
		for (int p = 0; p < PHASES; p++) begin
			sender_gaps_on = (p % 3 != 1);
			for (int m = 0; m < 4; m++) begin
				case ($urandom_range(0, 7))
					0:       traffic_macs[m] = '0;
					1:       traffic_macs[m] = MAC_ONES;
					default: traffic_macs[m] = 48'({$urandom(), $urandom()});
				endcase
			end
			now = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 : $urandom();
			for (int k = 0; k < per_phase; k++) begin
				if (k < 6 || $urandom_range(0, 15) == 0) begin
					send_request(random_load());
				end else begin
					if ($urandom_range(0, 24) == 0)
						now = $urandom();
					else
						now = now + $urandom_range(0, 20);
					send_request(random_packet(now));
				end
			end
			drain_verdicts();
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.data    = '0;
		burst_left     = 0;
		sender_gaps_on = 1'b1;
		mismatches     = 0;
		idle_cycles    = 0;
		n_packets      = 0;
		n_loads        = 0;
		n_matched      = 0;
		n_dropped      = 0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			tbl_valid[i]    = 1'b0;
			tbl_mac[i]      = '0;
			tbl_rate[i]     = '0;
			tbl_cap[i]      = '0;
			tbl_shift[i]    = '0;
			tbl_bkt_from[i] = '0;
			tbl_bkt_to[i]   = '0;
			tbl_last[i]     = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_zero_length_and_empty_bucket();
		test_extremes();
		test_direction();
		test_disable();
		test_walk_stop();
		test_time_wrap();
		drain_verdicts();
		test_random_traffic(RANDOM_ITEMS);

		drain_verdicts();
		repeat (WALK_CYCLES) @(posedge clk);
		$display("Run covered %0d packet requests (%0d matched a slot, %0d dropped)",
			n_packets, n_matched, n_dropped);
		$display("and %0d table loads, with random sender gaps and receiver stalls.", n_loads);
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
